/* hdl/dmr_pkg.sv */
// Shared types and constants of the dual motor ramp and direction interlock.
// Used by every module of the block; depends on nothing else.
package dmr_pkg;

	// Motor modes as they appear on the result stream.
	typedef enum logic [1:0] {
		MODE_STANDBY = 2'd0,
		MODE_FORWARD = 2'd1,
		MODE_REVERSE = 2'd2
	} mode_t;

	// Request kinds carried in tuser.
	typedef enum logic [1:0] {
		FUNC_VEL  = 2'd0,
		FUNC_TICK = 2'd1,
		FUNC_STOP = 2'd2,
		FUNC_SET  = 2'd3
	} func_t;

	// Register indexes, at byte address 4 * index.
	typedef enum logic [2:0] {
		REG_PERIOD    = 3'd0,
		REG_STEP_LEFT = 3'd1,
		REG_STEP_RGHT = 3'd2,
		REG_DEADBAND  = 3'd3,
		REG_STOP_THR  = 3'd4
	} reg_idx_t;

	localparam logic [15:0] PERIOD_RST   = 16'd999;
	localparam logic [15:0] STEP_RST     = 16'd20;
	localparam logic [14:0] DEADBAND_RST = 15'd328;
	localparam logic [15:0] STOP_THR_RST = 16'd100;

	// Velocity full scale, also the divisor of the duty goal.
	localparam logic [14:0] VEL_FULL = 15'd32767;

	// Result queue depth; it also bounds the requests in flight.
	localparam int unsigned QUEUE_DEPTH = 4;
	localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// Configuration register set.
	typedef struct packed {
		logic [15:0] period;
		logic [15:0] step_left;
		logic [15:0] step_right;
		logic [14:0] deadband;
		logic [15:0] stop_thr;
	} cfg_t;

	// What one lane shows after a step.
	typedef struct packed {
		mode_t       mode;
		logic [15:0] rev;
		logic [15:0] fwd;
	} lane_res_t;

endpackage

/* hdl/dmr_lane.sv */
// One motor lane: velocity decode and goal product (stage 1), then goal scaling,
// ramp and direction interlock on the motor state (stage 2). Depends on dmr_pkg.
module dmr_lane import dmr_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        load,
	input  logic        step,
	input  func_t       func,
	input  logic [15:0] vel,
	input  logic [15:0] period,
	input  logic [15:0] ramp_step,
	input  logic [14:0] deadband,
	input  logic [15:0] stop_thr,
	output lane_res_t   res
);

	// Stage 1 front: saturate, magnitude, wanted direction, product.
	logic signed [15:0] vel_sat;
	logic signed [16:0] vel_ext;
	logic signed [16:0] db_pos;
	logic signed [16:0] db_neg;
	logic        [15:0] vel_neg;
	logic        [14:0] mag;
	logic        [30:0] prod_c;
	mode_t              want_c;

	always_comb begin
		vel_sat = (vel == 16'h8000) ? 16'sh8001 : signed'(vel);
		vel_ext = 17'(vel_sat);
		db_pos  = signed'({2'b00, deadband});
		db_neg  = -db_pos;
		vel_neg = 16'(-vel_sat);
		mag     = vel_sat[15] ? vel_neg[14:0] : vel_sat[14:0];
		prod_c  = 31'(mag) * 31'(period);
		if (vel_ext > db_pos) begin
			want_c = MODE_FORWARD;
		end else if (vel_ext < db_neg) begin
			want_c = MODE_REVERSE;
		end else begin
			want_c = MODE_STANDBY;
		end
	end

	// Stage 1 payload registers.
	func_t       func_s1;
	mode_t       want_s1;
	logic [30:0] prod_s1;

	always_ff @(posedge clk) begin
		if (load) begin
			func_s1 <= func;
			want_s1 <= want_c;
			prod_s1 <= prod_c;
		end
	end

	// Division of the product by 32767 through two folds of the high part
	// into the low part and one final correction.
	logic [15:0] q0;
	logic [16:0] fold1;
	logic [1:0]  q1;
	logic [15:0] fold2;
	logic        q2;
	logic [15:0] goal_c;

	always_comb begin
		q0     = prod_s1[30:15];
		fold1  = 17'(q0) + 17'(prod_s1[14:0]);
		q1     = fold1[16:15];
		fold2  = 16'(q1) + 16'(fold1[14:0]);
		q2     = (fold2 >= 16'(VEL_FULL));
		goal_c = q0 + 16'(q1) + 16'(q2);
	end

	// Motor state.
	logic [15:0] duty_q;
	logic [15:0] goal_q;
	mode_t       mode_q;
	logic [15:0] fwd_q;
	logic [15:0] rev_q;

	logic [15:0] duty_d;
	logic [15:0] goal_d;
	mode_t       mode_d;
	logic [15:0] fwd_d;
	logic [15:0] rev_d;
	logic [15:0] diff;

	// Next state for the request in stage 2.
	always_comb begin
		duty_d = duty_q;
		goal_d = goal_q;
		mode_d = mode_q;
		fwd_d  = fwd_q;
		rev_d  = rev_q;
		diff   = '0;
		case (func_s1)
			FUNC_VEL: begin
				if (mode_q != want_s1) begin
					goal_d = '0;
					if (duty_q < stop_thr) begin
						mode_d = want_s1;
						// The channel that the new mode does not drive is cleared.
						case (want_s1)
							MODE_FORWARD: rev_d = '0;
							MODE_REVERSE: fwd_d = '0;
							default: begin
								fwd_d = '0;
								rev_d = '0;
							end
						endcase
					end
				end else begin
					goal_d = goal_c;
				end
			end
			FUNC_TICK: begin
				// Move toward the goal by at most one step, landing on it.
				if (duty_q < goal_q) begin
					diff   = goal_q - duty_q;
					duty_d = (diff > ramp_step) ? duty_q + ramp_step : goal_q;
				end else if (duty_q > goal_q) begin
					diff   = duty_q - goal_q;
					duty_d = (diff > ramp_step) ? duty_q - ramp_step : goal_q;
				end
				fwd_d = (mode_q == MODE_FORWARD) ? duty_d : '0;
				rev_d = (mode_q == MODE_REVERSE) ? duty_d : '0;
			end
			FUNC_STOP: begin
				mode_d = MODE_STANDBY;
				goal_d = '0;
				fwd_d  = '0;
				rev_d  = '0;
			end
			FUNC_SET: begin
				goal_d = goal_c;
			end
			default: begin
				goal_d = goal_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			duty_q <= '0;
			goal_q <= '0;
			mode_q <= MODE_STANDBY;
			fwd_q  <= '0;
			rev_q  <= '0;
		end else if (step) begin
			duty_q <= duty_d;
			goal_q <= goal_d;
			mode_q <= mode_d;
			fwd_q  <= fwd_d;
			rev_q  <= rev_d;
		end
	end

	// The state after this step is the lane's result.
	assign res.mode = mode_d;
	assign res.fwd  = fwd_d;
	assign res.rev  = rev_d;

endmodule

/* hdl/dmr_merge.sv */
// Merge stage: joins the two lane results into one result and queues it for
// the output stream. Depends on dmr_pkg.
module dmr_merge import dmr_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  lane_res_t         res_left,
	input  lane_res_t         res_right,
	output logic [QCNT_W-1:0] count,
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [71:0]       m_tdata
);

	logic [67:0]       mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              pop;
	logic [67:0]       word;

	assign pop  = m_tvalid && m_tready;
	assign word = {res_right.mode, res_left.mode, res_right.rev, res_right.fwd,
		res_left.rev, res_left.fwd};

	// Queue storage.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= word;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	assign count    = count_q;
	assign m_tvalid = (count_q != '0);
	assign m_tdata  = {4'b0000, mem_q[rd_ptr_q]};

endmodule

/* hdl/dual_motor_ramp_direction_interlock.sv */
// Dual H-bridge motor driver with ramped duty and direction interlock.
// With an empty queue, a request's result is offered after its stage 1 registers and its write into the result queue.
// Throughput: one request per cycle; the four-entry result queue sets the stall point.
// Every request yields one result, the motor state after the request.
// Reset (arst_n low) clears duties, goals, modes, compare values and the queue,
// and loads the register defaults.
module dual_motor_ramp_direction_interlock import dmr_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	// Request stream.
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // vel_left [15:0], vel_right [31:16]
	input  logic [1:0]  s_tuser,   // func [1:0]
	// Result stream.
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [71:0] m_tdata,   // fwd_left, rev_left, fwd_right, rev_right (16 each),
	                               // mode_left [65:64], mode_right [67:66], zero fill
	// Register port.
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	cfg_t     cfg_q;
	reg_idx_t idx;

	assign idx    = reg_idx_t'(paddr[4:2]);
	assign pready = 1'b1;

	// Register writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.period     <= PERIOD_RST;
			cfg_q.step_left  <= STEP_RST;
			cfg_q.step_right <= STEP_RST;
			cfg_q.deadband   <= DEADBAND_RST;
			cfg_q.stop_thr   <= STOP_THR_RST;
		end else if (psel && penable && pwrite && pready) begin
			case (idx)
				REG_PERIOD:    cfg_q.period     <= pwdata[15:0];
				REG_STEP_LEFT: cfg_q.step_left  <= pwdata[15:0];
				REG_STEP_RGHT: cfg_q.step_right <= pwdata[15:0];
				REG_DEADBAND:  cfg_q.deadband   <= pwdata[14:0];
				REG_STOP_THR:  cfg_q.stop_thr   <= pwdata[15:0];
				default: begin
					cfg_q <= cfg_q;
				end
			endcase
		end
	end

	// Register reads.
	always_comb begin
		case (idx)
			REG_PERIOD:    prdata = {16'd0, cfg_q.period};
			REG_STEP_LEFT: prdata = {16'd0, cfg_q.step_left};
			REG_STEP_RGHT: prdata = {16'd0, cfg_q.step_right};
			REG_DEADBAND:  prdata = {17'd0, cfg_q.deadband};
			REG_STOP_THR:  prdata = {16'd0, cfg_q.stop_thr};
			default:       prdata = '0;
		endcase
	end

	// Request acceptance, bounded by the free queue space.
	logic              accept;
	logic              v_s1;
	logic [QCNT_W-1:0] count;
	logic [QCNT_W-1:0] in_flight;
	func_t             func;
	logic [15:0]       vel_right_lane;

	assign in_flight = count + QCNT_W'(v_s1);
	assign s_tready  = (in_flight < QCNT_W'(QUEUE_DEPTH));
	assign accept    = s_tvalid && s_tready;
	assign func      = func_t'(s_tuser);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= accept;
		end
	end

	// A magnitude set drives both goals from the left velocity.
	assign vel_right_lane = (func == FUNC_SET) ? s_tdata[15:0] : s_tdata[31:16];

	lane_res_t res_left;
	lane_res_t res_right;

	dmr_lane u_lane_left (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (accept),
		.step      (v_s1),
		.func      (func),
		.vel       (s_tdata[15:0]),
		.period    (cfg_q.period),
		.ramp_step (cfg_q.step_left),
		.deadband  (cfg_q.deadband),
		.stop_thr  (cfg_q.stop_thr),
		.res       (res_left)
	);

	dmr_lane u_lane_right (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (accept),
		.step      (v_s1),
		.func      (func),
		.vel       (vel_right_lane),
		.period    (cfg_q.period),
		.ramp_step (cfg_q.step_right),
		.deadband  (cfg_q.deadband),
		.stop_thr  (cfg_q.stop_thr),
		.res       (res_right)
	);

	dmr_merge u_merge (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (v_s1),
		.res_left  (res_left),
		.res_right (res_right),
		.count     (count),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

endmodule

/* hdl/dmr_checker.sv */
// Port-level checks of the dual motor driver: result stream stability and the
// direction interlock on the compare values. Depends on dmr_pkg.
module dmr_checker import dmr_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [71:0] m_tdata
);

	// A stalled result stays offered.
	a_valid_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result withdrawn while stalled");

	// A stalled result keeps its value.
	a_data_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata))
		else $error("result changed while stalled");

	// Left motor: never both channels driven, and nothing driven in standby.
	a_left_lock: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[15:0] == 16'd0 || m_tdata[31:16] == 16'd0) &&
		(m_tdata[65:64] != MODE_STANDBY || (m_tdata[15:0] == 16'd0 && m_tdata[31:16] == 16'd0)))
		else $error("left motor interlock violated");

	// Right motor: same interlock.
	a_right_lock: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[47:32] == 16'd0 || m_tdata[63:48] == 16'd0) &&
		(m_tdata[67:66] != MODE_STANDBY || (m_tdata[47:32] == 16'd0 && m_tdata[63:48] == 16'd0)))
		else $error("right motor interlock violated");

endmodule

bind dual_motor_ramp_direction_interlock dmr_checker u_dmr_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

/* sim/dual_motor_ramp_direction_interlock_tb.sv */
// Self-checking testbench of the dual motor ramp and direction interlock.
// Needs dmr_pkg and dual_motor_ramp_direction_interlock; it predicts every result in
// step with the accepted requests and compares the result stream field by field.
`timescale 1ns / 1ps

module dual_motor_ramp_direction_interlock_tb;
	import dmr_pkg::*;

	localparam int WATCHDOG_LIMIT = 5000;
	localparam int LONG_HOLD      = 400;
	localparam int PHASES         = 7;
	localparam int PHASE_ITEMS    = 145;

	typedef struct {
		func_t       func;
		logic [15:0] vl;
		logic [15:0] vr;
	} motor_cmd_t;

	typedef struct {
		logic [15:0] fwd_l, rev_l, fwd_r, rev_r;
		mode_t       mode_l, mode_r;
	} motor_res_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata = '0;
	logic [1:0]  s_tuser = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [71:0] m_tdata;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [4:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	dual_motor_ramp_direction_interlock i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Register shadow, state of both motor lanes, and the queues around the block.
	logic [15:0] cfg_period, cfg_stop_thr;
	logic [15:0] cfg_step [0:1];
	logic [14:0] cfg_deadband;
	logic [15:0] duty_now [0:1];
	logic [15:0] duty_goal [0:1];
	mode_t       lane_mode [0:1];
	logic [15:0] cmp [0:3];

	motor_cmd_t cmd_q [$];
	motor_res_t motor_exp_q [$];
	motor_cmd_t cur_cmd;

	int n_err = 0;
	int n_res = 0;
	int n_func [0:3] = '{0, 0, 0, 0};
	int tx_gap = 0;
	bit tx_burst = 1'b0;
	bit tx_rush = 1'b0;
	int rx_stall = 0;
	bit rx_burst = 1'b0;
	bit hold_req = 1'b0;
	int hold_cnt = 0;
	int idle_cycles = 0;

	// Signed velocity with the most negative code saturated to the negative full scale.
	function automatic int vel_of(logic [15:0] raw);
		int v;
		v = $signed(raw);
		if (v < -32767)
			v = -32767;
		return v;
	endfunction

	// Duty goal for a velocity magnitude, rounded down.
	function automatic logic [15:0] goal_of(int m);
		longint unsigned p;
		p = m;
		return 16'((p * cfg_period) / VEL_FULL);
	endfunction

	// A velocity command on one lane, with the direction interlock.
	function automatic void lane_command(int k, int v);
		mode_t want;
		int    db;
		db = cfg_deadband;
		if (v > db)
			want = MODE_FORWARD;
		else if (v < -db)
			want = MODE_REVERSE;
		else
			want = MODE_STANDBY;
		if (lane_mode[k] != want) begin
			duty_goal[k] = '0;
			if (duty_now[k] < cfg_stop_thr) begin
				lane_mode[k] = want;
				// The channel that the new mode does not drive goes to zero.
				if (want != MODE_REVERSE)
					cmp[2*k+1] = '0;
				if (want != MODE_FORWARD)
					cmp[2*k] = '0;
			end
		end else begin
			duty_goal[k] = goal_of(v < 0 ? -v : v);
		end
	endfunction

	// One ramp tick on one lane; the duty lands exactly on the goal.
	function automatic void lane_ramp(int k, logic [15:0] step);
		logic [15:0] d, g;
		d = duty_now[k];
		g = duty_goal[k];
		if (d < g)
			d = (g - d > step) ? d + step : g;
		else if (d > g)
			d = (d - g > step) ? d - step : g;
		duty_now[k] = d;
		cmp[2*k]   = (lane_mode[k] == MODE_FORWARD) ? d : '0;
		cmp[2*k+1] = (lane_mode[k] == MODE_REVERSE) ? d : '0;
	endfunction

	// Motor state after one request.
	function automatic motor_res_t motor_step(motor_cmd_t c);
		motor_res_t r;
		logic [15:0] g;
		int v;
		case (c.func)
			FUNC_VEL: begin
				lane_command(0, vel_of(c.vl));
				lane_command(1, vel_of(c.vr));
			end
			FUNC_TICK: begin
				lane_ramp(0, cfg_step[0]);
				lane_ramp(1, cfg_step[1]);
			end
			FUNC_STOP: begin
				for (int k = 0; k < 2; k++) begin
					lane_mode[k] = MODE_STANDBY;
					duty_goal[k] = '0;
				end
				for (int i = 0; i < 4; i++)
					cmp[i] = '0;
			end
			default: begin
				v = vel_of(c.vl);
				g = goal_of(v < 0 ? -v : v);
				duty_goal[0] = g;
				duty_goal[1] = g;
			end
		endcase
		r.fwd_l  = cmp[0];
		r.rev_l  = cmp[1];
		r.fwd_r  = cmp[2];
		r.rev_r  = cmp[3];
		r.mode_l = lane_mode[0];
		r.mode_r = lane_mode[1];
		return r;
	endfunction

	function automatic void check_field(string name, logic [15:0] e, logic [15:0] a);
		if (e !== a) begin
			$error("%s: expected %0d, got %0d", name, e, a);
			n_err++;
		end
	endfunction

	// Driver: takes requests from the pending queue, with a random gap after each one.
	always @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			motor_exp_q.push_back(motor_step(cur_cmd));
			n_func[cur_cmd.func]++;
		end
		if (!s_tvalid || s_tready) begin
			if (tx_gap > 0) begin
				tx_gap--;
				s_tvalid <= 1'b0;
			end else if (cmd_q.size() > 0) begin
				cur_cmd = cmd_q.pop_front();
				s_tvalid <= 1'b1;
				s_tuser <= cur_cmd.func;
				s_tdata <= {cur_cmd.vr, cur_cmd.vl};
				if ($urandom_range(0, 15) == 0)
					tx_burst = !tx_burst;
				tx_gap = (tx_burst || tx_rush) ? 0 : $urandom_range(0, 18);
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// Monitor: checks each result against the oldest expectation and stalls at random.
	always @(posedge clk) begin
		motor_res_t exp_res;
		if (m_tvalid && m_tready) begin
			if (motor_exp_q.size() == 0) begin
				$error("result with no request outstanding: %h", m_tdata);
				n_err++;
			end else begin
				exp_res = motor_exp_q.pop_front();
				check_field("fwd_left", exp_res.fwd_l, m_tdata[15:0]);
				check_field("rev_left", exp_res.rev_l, m_tdata[31:16]);
				check_field("fwd_right", exp_res.fwd_r, m_tdata[47:32]);
				check_field("rev_right", exp_res.rev_r, m_tdata[63:48]);
				check_field("mode_left", exp_res.mode_l, m_tdata[65:64]);
				check_field("mode_right", exp_res.mode_r, m_tdata[67:66]);
				check_field("zero_fill", '0, m_tdata[71:68]);
				n_res++;
			end
			if ($urandom_range(0, 15) == 0)
				rx_burst = !rx_burst;
			rx_stall = rx_burst ? 0 : $urandom_range(0, 18);
		end
		if (hold_req) begin
			hold_req = 1'b0;
			hold_cnt = LONG_HOLD;
		end
		if (hold_cnt > 0) begin
			hold_cnt--;
			m_tready <= 1'b0;
		end else if (rx_stall > 0) begin
			rx_stall--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	// Watchdog: counts busy cycles in which neither stream moves.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) ||
		    !(s_tvalid || cmd_q.size() > 0 || motor_exp_q.size() > 0)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("Timeout: %0d cycles without progress", idle_cycles);
				$display("[dual_motor_ramp_direction_interlock] ERROR");
				$finish;
			end
		end
	end

	// Register write: setup cycle, then access cycle until pready.
	task automatic reg_write(reg_idx_t idx, logic [31:0] val);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_PERIOD:    cfg_period = val[15:0];
			REG_STEP_LEFT: cfg_step[0] = val[15:0];
			REG_STEP_RGHT: cfg_step[1] = val[15:0];
			REG_DEADBAND:  cfg_deadband = val[14:0];
			REG_STOP_THR:  cfg_stop_thr = val[15:0];
			default: ;
		endcase
	endtask

	task automatic push_cmd(func_t f, logic [15:0] vl, logic [15:0] vr);
		motor_cmd_t c;
		c.func = f;
		c.vl = vl;
		c.vr = vr;
		cmd_q.push_back(c);
	endtask

	// Velocity code: raw bits, full scale, around the deadband edge, zero or any magnitude.
	function automatic logic [15:0] rand_vel();
		int m;
		case ($urandom_range(0, 5))
			0: return 16'($urandom);
			1: begin
				case ($urandom_range(0, 2))
					0: return 16'h7FFF;
					1: return 16'h8001;
					default: return 16'h8000;
				endcase
			end
			2: begin
				m = int'(cfg_deadband) + $urandom_range(0, 4) - 2;
				if (m < 0)
					m = 0;
				if (m > 32767)
					m = 32767;
			end
			3: return 16'h0000;
			default: m = $urandom_range(0, 32767);
		endcase
		return $urandom_range(0, 1) ? 16'(m) : 16'(-m);
	endfunction

	// Mostly a command followed by a run of ticks, so that ramps and reversals play out.
	task automatic push_random(int n);
		int done, ticks, kind;
		done = 0;
		while (done < n) begin
			kind = $urandom_range(0, 19);
			ticks = ($urandom_range(0, 4) == 0) ? $urandom_range(15, 60) : $urandom_range(0, 10);
			if (kind < 13) begin
				push_cmd(FUNC_VEL, rand_vel(), rand_vel());
			end else if (kind < 16) begin
				push_cmd(FUNC_SET, rand_vel(), rand_vel());
			end else if (kind < 17) begin
				push_cmd(FUNC_STOP, rand_vel(), rand_vel());
			end else begin
				push_cmd(func_t'($urandom_range(0, 3)), 16'($urandom), 16'($urandom));
				ticks = 0;
			end
			repeat (ticks)
				push_cmd(FUNC_TICK, 16'($urandom), 16'($urandom));
			done += 1 + ticks;
		end
	endtask

	task automatic wait_drained();
		while (cmd_q.size() > 0 || s_tvalid || motor_exp_q.size() > 0)
			@(negedge clk);
		repeat (4)
			@(negedge clk);
	endtask

	// Stimulus: directed requests, then one random phase per register setting.
	initial begin
		logic [15:0] plan [0:4];
		cfg_period = PERIOD_RST;
		cfg_step[0] = STEP_RST;
		cfg_step[1] = STEP_RST;
		cfg_deadband = DEADBAND_RST;
		cfg_stop_thr = STOP_THR_RST;
		for (int k = 0; k < 2; k++) begin
			duty_now[k] = '0;
			duty_goal[k] = '0;
			lane_mode[k] = MODE_STANDBY;
		end
		for (int i = 0; i < 4; i++)
			cmp[i] = '0;
		repeat (3)
			@(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Full scale both ways: the first command only switches the modes.
		push_cmd(FUNC_VEL, 16'h7FFF, 16'h8001);
		push_cmd(FUNC_VEL, 16'h7FFF, 16'h8001);
		repeat (6)
			push_cmd(FUNC_TICK, 16'h0000, 16'hFFFF);
		// Reversal above the stop threshold is held off until the duty has ramped down.
		push_cmd(FUNC_VEL, 16'h8000, 16'h7FFF);
		push_cmd(FUNC_TICK, 16'hFFFF, 16'h0000);
		push_cmd(FUNC_TICK, 16'h0000, 16'h0000);
		push_cmd(FUNC_VEL, 16'h8000, 16'h7FFF);
		push_cmd(FUNC_VEL, 16'h8000, 16'h7FFF);
		push_cmd(FUNC_TICK, 16'h0000, 16'h0000);
		// Both magnitudes from the left velocity; the right one is ignored.
		push_cmd(FUNC_SET, 16'h8000, 16'h1234);
		push_cmd(FUNC_TICK, 16'h0000, 16'h0000);
		// Deadband edges, then stop, then ramping in standby with both channels at zero.
		push_cmd(FUNC_VEL, 16'd328, -16'sd328);
		push_cmd(FUNC_VEL, 16'd329, -16'sd329);
		push_cmd(FUNC_STOP, 16'h7FFF, 16'h7FFF);
		push_cmd(FUNC_TICK, 16'h0000, 16'h0000);
		push_cmd(FUNC_VEL, 16'h0000, 16'h0000);
		push_cmd(FUNC_SET, 16'h7FFF, 16'h0000);
		push_cmd(FUNC_TICK, 16'h0000, 16'h0000);
		push_cmd(FUNC_VEL, 16'hFFFF, 16'h7FFE);
		push_random(PHASE_ITEMS);

		for (int p = 1; p < PHASES; p++) begin
			wait_drained();
			case (p)
				1: plan = '{16'd2000, 16'd100, 16'd7, 16'd1000, 16'd500};
				2: plan = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd0, 16'hFFFF};
				3: plan = '{16'd1, 16'd1, 16'd0, 16'h7FFF, 16'd0};
				4: plan = '{16'd0, 16'd0, 16'd300, 16'd5, 16'd50};
				5: plan = '{16'($urandom_range(1, 65535)), 16'($urandom_range(0, 2000)),
				            16'($urandom_range(0, 2000)), 16'($urandom_range(0, 8000)),
				            16'($urandom_range(0, 3000))};
				default: plan = '{PERIOD_RST, STEP_RST, STEP_RST, 16'(DEADBAND_RST), STOP_THR_RST};
			endcase
			for (int i = 0; i < 5; i++)
				reg_write(reg_idx_t'(i), {16'h0000, plan[i]});
			@(negedge clk);
			if (p == 1) begin
				// Receiver holds off while requests keep coming back to back.
				tx_rush = 1'b1;
				hold_req = 1'b1;
				push_random(30);
				while (cmd_q.size() > 0)
					@(negedge clk);
				tx_rush = 1'b0;
			end
			push_random(PHASE_ITEMS);
		end

		wait_drained();
		repeat (10)
			@(negedge clk);
		if (motor_exp_q.size() != 0) begin
			$error("%0d results never arrived", motor_exp_q.size());
			n_err++;
		end
		$display("Ran %0d register settings: %0d velocity, %0d tick, %0d stop, %0d set requests.",
		         PHASES, n_func[0], n_func[1], n_func[2], n_func[3]);
		$display("Checked %0d results with %0d mismatches.", n_res, n_err);
		if (n_err == 0)
			$display("[dual_motor_ramp_direction_interlock] OK");
		else
			$display("[dual_motor_ramp_direction_interlock] ERROR");
		$finish;
	end

endmodule

/* dual_motor_ramp_direction_interlock.f */
hdl/dmr_pkg.sv
hdl/dmr_lane.sv
hdl/dmr_merge.sv
hdl/dual_motor_ramp_direction_interlock.sv
hdl/dmr_checker.sv
sim/dual_motor_ramp_direction_interlock_tb.sv
